// ===== sv/adc_scan_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// adc_scan_sequencer assertion macros
// Clocked assertion wrappers used by the sequencer's control module.
// ----------------------------------------------------------------------------
`ifndef ADC_SCAN_SEQUENCER_ASSERT_SVH
`define ADC_SCAN_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
// assertion held off while the reset is asserted
`define ADCSEQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// assertion checked at every edge, reset included
`define ADCSEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADCSEQ_ASSERT(lbl, clk, rst, prop, msg)
`define ADCSEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/adcseq_pkg.sv =====
// ----------------------------------------------------------------------------
// adcseq_pkg
// Types, codes and constants of the ADC scan sequencer.
// ----------------------------------------------------------------------------
package adcseq_pkg;

  localparam int MAX_CHAIN    = 8;
  localparam int LAST_CHANNEL = 7;
  localparam int TABLE_DEPTH  = 8;
  localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

  localparam logic [15:0] TIMEOUT_RESET = 16'd50000;

  // command codes
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_SINGLE = 3'd1;
  localparam logic [2:0] CMD_CHAIN  = 3'd2;
  localparam logic [2:0] CMD_DONE   = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // request modes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_CHAIN  = 2'd1;
  localparam logic [1:0] MODE_POLLED = 2'd2;

  // configuration register indexes
  localparam logic CFG_LEFT_ADJUST = 1'b0;
  localparam logic CFG_TIMEOUT     = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  channel;
    logic [2:0]  slot;
    logic [3:0]  chain_length;
    logic        polled;
    logic [15:0] raw_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] sample_value;
    logic       sample_valid;
    logic [2:0] sample_index;
    logic       start_conversion;
    logic [2:0] mux_channel;
    logic       finished;
    logic       busy_res;
  } out_item_t;

  // table access issued by the control logic
  typedef struct packed {
    logic                wr_en;
    logic [TABLE_AW-1:0] wr_addr;
    logic [4:0]          wr_data;
    logic                rd_en;
    logic [TABLE_AW-1:0] rd_addr;
  } table_req_t;

  // table answer: registered read data and the per-slot bad-channel flags
  typedef struct packed {
    logic [4:0]             rd_data;
    logic [TABLE_DEPTH-1:0] bad;
  } table_rsp_t;

  function automatic logic [9:0] unpack(input logic [15:0] raw, input logic left);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = raw[15:8];
    lo = raw[7:0];
    return left ? {hi, lo[7:6]} : {hi[1:0], lo};
  endfunction

endpackage

// ===== sv/adcseq_if.sv =====
// ----------------------------------------------------------------------------
// adcseq_if
// Valid/ready channels carrying command beats and result beats.
// ----------------------------------------------------------------------------
interface adcseq_in_if;
  logic                 valid;
  logic                 ready;
  adcseq_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface adcseq_out_if;
  logic                  valid;
  logic                  ready;
  adcseq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/adcseq_table.sv =====
// ----------------------------------------------------------------------------
// adcseq_table
// Channel table memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module adcseq_table (
  input  logic                   clk,
  input  logic                   rst,
  input  adcseq_pkg::table_req_t req,
  output adcseq_pkg::table_rsp_t rsp
);

  logic [4:0]                         mem [adcseq_pkg::TABLE_DEPTH];
  logic [adcseq_pkg::TABLE_DEPTH-1:0] written;
  logic [adcseq_pkg::TABLE_DEPTH-1:0] bad;
  logic [4:0]                         mem_q;
  logic                               written_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q     <= mem[req.rd_addr];
      written_q <= written[req.rd_addr];
    end
  end

  // unwritten slots read as channel 0, which is a legal channel
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      bad     <= '0;
    end else if (req.wr_en) begin
      written[req.wr_addr] <= 1'b1;
      bad[req.wr_addr]     <= (req.wr_data > 5'(adcseq_pkg::LAST_CHANNEL));
    end
  end

  assign rsp.rd_data = written_q ? mem_q : 5'd0;
  assign rsp.bad     = bad;

endmodule

// ===== sv/adcseq_skid.sv =====
// ----------------------------------------------------------------------------
// adcseq_skid
// Two-entry skid buffer on the result channel.
// ----------------------------------------------------------------------------
module adcseq_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  input  adcseq_pkg::out_item_t data,
  output logic                  ready,
  adcseq_out_if.source          results
);

  logic                  main_valid;
  adcseq_pkg::out_item_t main_data;
  logic                  skid_valid;
  adcseq_pkg::out_item_t skid_data;

  assign ready         = !skid_valid;
  assign results.valid = main_valid;
  assign results.data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (valid && ready) begin
      if (main_valid && !results.ready) begin
        skid_valid <= 1'b1;
        skid_data  <= data;
      end else begin
        main_valid <= 1'b1;
        main_data  <= data;
      end
    end else if (results.ready) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/adcseq_ctrl.sv =====
// ----------------------------------------------------------------------------
// adcseq_ctrl
// Command decode, request state and the result stage.
// ----------------------------------------------------------------------------
`include "adc_scan_sequencer_assert.svh"

module adcseq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data,
  adcseq_in_if.sink              items,
  output adcseq_pkg::table_req_t tbl_req,
  input  adcseq_pkg::table_rsp_t tbl_rsp,
  output logic                   res_valid,
  output adcseq_pkg::out_item_t  res_data,
  input  logic                   res_ready
);

  typedef struct packed {
    adcseq_pkg::out_item_t res;
    logic                  from_table;
  } stage_t;

  // configuration
  logic        left_adjust;
  logic [15:0] timeout_limit;

  // request state
  logic        busy;
  logic [1:0]  mode;
  logic [3:0]  chain_total;
  logic [2:0]  chain_pos;
  logic [15:0] wait_cnt;

  logic        busy_next;
  logic [1:0]  mode_next;
  logic [3:0]  chain_total_next;
  logic [2:0]  chain_pos_next;
  logic [15:0] wait_cnt_next;

  logic                   accept;
  logic                   chain_ok;
  logic [2:0]             pos_inc;
  logic [15:0]            wait_inc;
  adcseq_pkg::in_item_t   it;
  adcseq_pkg::table_req_t req;
  stage_t                 st_next;
  stage_t                 s1;
  logic                   s1_valid;

  assign it           = items.data;
  assign items.ready  = !s1_valid || res_ready;
  assign accept       = items.valid && items.ready;
  assign pos_inc      = chain_pos + 3'd1;
  assign wait_inc     = wait_cnt + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_adjust   <= 1'b0;
      timeout_limit <= adcseq_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adcseq_pkg::CFG_LEFT_ADJUST: left_adjust   <= cfg_data[0];
        adcseq_pkg::CFG_TIMEOUT:     timeout_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // length and every listed slot must hold a legal channel
  always_comb begin
    chain_ok = (it.chain_length != 4'd0)
            && (int'(it.chain_length) <= adcseq_pkg::MAX_CHAIN)
            && (int'(it.chain_length) <= adcseq_pkg::TABLE_DEPTH);
    for (int i = 0; i < adcseq_pkg::TABLE_DEPTH; i++) begin
      if ((i < int'(it.chain_length)) && tbl_rsp.bad[i]) begin
        chain_ok = 1'b0;
      end
    end
  end

  always_comb begin
    st_next          = '0;
    req              = '0;
    busy_next        = busy;
    mode_next        = mode;
    chain_total_next = chain_total;
    chain_pos_next   = chain_pos;
    wait_cnt_next    = wait_cnt;
    st_next.res.status = adcseq_pkg::ST_OK;

    unique case (it.cmd)
      adcseq_pkg::CMD_LOAD: begin
        if (busy) begin
          st_next.res.status = adcseq_pkg::ST_BUSY;
        end else begin
          req.wr_en   = 1'b1;
          req.wr_addr = it.slot;
          req.wr_data = it.channel;
        end
      end
      adcseq_pkg::CMD_SINGLE: begin
        if (it.channel > 5'(adcseq_pkg::LAST_CHANNEL)) begin
          st_next.res.status = adcseq_pkg::ST_INVALID;
        end else if (busy) begin
          st_next.res.status = adcseq_pkg::ST_BUSY;
        end else begin
          busy_next = 1'b1;
          mode_next = it.polled ? adcseq_pkg::MODE_POLLED : adcseq_pkg::MODE_SINGLE;
          wait_cnt_next = 16'd0;
          st_next.res.start_conversion = 1'b1;
          st_next.res.mux_channel      = it.channel[2:0];
        end
      end
      adcseq_pkg::CMD_CHAIN: begin
        if (!chain_ok) begin
          st_next.res.status = adcseq_pkg::ST_INVALID;
        end else if (busy) begin
          st_next.res.status = adcseq_pkg::ST_BUSY;
        end else begin
          busy_next        = 1'b1;
          mode_next        = adcseq_pkg::MODE_CHAIN;
          chain_total_next = it.chain_length;
          chain_pos_next   = 3'd0;
          st_next.res.start_conversion = 1'b1;
          st_next.from_table = 1'b1;
          req.rd_en   = 1'b1;
          req.rd_addr = '0;
        end
      end
      adcseq_pkg::CMD_DONE: begin
        if (!busy) begin
          st_next.res.status = adcseq_pkg::ST_IGNORED;
        end else begin
          st_next.res.sample_value = adcseq_pkg::unpack(it.raw_data, left_adjust);
          st_next.res.sample_valid = 1'b1;
          if (mode == adcseq_pkg::MODE_CHAIN) begin
            st_next.res.sample_index = chain_pos;
            chain_pos_next = pos_inc;
            if (({1'b0, chain_pos} + 4'd1) >= chain_total) begin
              st_next.res.finished = 1'b1;
              busy_next = 1'b0;
            end else begin
              st_next.res.start_conversion = 1'b1;
              st_next.from_table = 1'b1;
              req.rd_en   = 1'b1;
              req.rd_addr = pos_inc;
            end
          end else begin
            st_next.res.finished = 1'b1;
            busy_next = 1'b0;
          end
        end
      end
      adcseq_pkg::CMD_TICK: begin
        if (busy && (mode == adcseq_pkg::MODE_POLLED)) begin
          wait_cnt_next = wait_inc;
          if (wait_inc >= timeout_limit) begin
            st_next.res.status   = adcseq_pkg::ST_TIMEOUT;
            st_next.res.finished = 1'b1;
            busy_next = 1'b0;
          end
        end else begin
          st_next.res.status = adcseq_pkg::ST_IGNORED;
        end
      end
      default: begin
        st_next.res.status = adcseq_pkg::ST_IGNORED;
      end
    endcase
    st_next.res.busy_res = busy_next;
  end

  // table access only for an accepted beat; the read data then holds with s1
  always_comb begin
    tbl_req       = req;
    tbl_req.wr_en = req.wr_en && accept;
    tbl_req.rd_en = req.rd_en && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      mode        <= adcseq_pkg::MODE_SINGLE;
      chain_total <= 4'd0;
      chain_pos   <= 3'd0;
      wait_cnt    <= 16'd0;
      s1_valid    <= 1'b0;
    end else if (accept) begin
      busy        <= busy_next;
      mode        <= mode_next;
      chain_total <= chain_total_next;
      chain_pos   <= chain_pos_next;
      wait_cnt    <= wait_cnt_next;
      s1_valid    <= 1'b1;
    end else if (res_ready) begin
      s1_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= st_next;
    end
  end

  always_comb begin
    res_data = s1.res;
    if (s1.from_table) begin
      res_data.mux_channel = tbl_rsp.rd_data[2:0];
    end
  end
  assign res_valid = s1_valid;

  `ADCSEQ_ASSERT(a_finish_no_start, clk, rst, s1_valid && s1.res.finished |-> !s1.res.start_conversion, "finished result also starts a conversion")
  `ADCSEQ_ASSERT(a_busy_fall, clk, rst, $fell(busy) |-> s1_valid && s1.res.finished, "busy cleared without a finished result")
  `ADCSEQ_ASSERT(a_chain_pos, clk, rst, busy && (mode == adcseq_pkg::MODE_CHAIN) |-> ({1'b0, chain_pos} < chain_total), "chain position beyond chain length")
  `ADCSEQ_ASSERT(a_busy_res, clk, rst, s1_valid && $rose(s1_valid) |-> (s1.res.busy_res == busy), "result busy flag differs from state")

endmodule

// ===== sv/adc_scan_sequencer.sv =====
// ----------------------------------------------------------------------------
// adc_scan_sequencer
// Command sequencer for a 10-bit ADC with an eight-slot channel table.
// ----------------------------------------------------------------------------
// Usage:
//   items   - command beats (load slot, start single, start chain,
//             conversion done, tick), valid/ready.
//   results - exactly one result beat per command beat, in order.
//   cfg_*   - register writes (left adjust, timeout limit); issue them only
//             while no command is outstanding.
// Path: a result is decided in the cycle its command is accepted, is
//   registered in the result stage along with the table read, then in the
//   skid buffer's output register, and is presented from there on results.
// Throughput: one command per cycle unless stalled; the channel table is a
//   single-port-read memory and each command needs at most one read.
// Reset: table reads as all channel 0, sequencer idle, left adjust off,
//   timeout limit 50000. No clearing pass: per-slot written flags cover it.
// Stall: a stalled receiver fills the result stage and the two-entry skid;
//   items.ready then drops until results drain. No beat is dropped.
// ----------------------------------------------------------------------------
module adc_scan_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  adcseq_in_if.sink   items,
  adcseq_out_if.source results
);

  adcseq_pkg::table_req_t tbl_req;   // write on load, read for chain mux
  adcseq_pkg::table_rsp_t tbl_rsp;   // registered read data, bad-slot flags

  logic                  res_valid;  // result stage occupied
  adcseq_pkg::out_item_t res_data;
  logic                  res_ready;  // skid has room (registered)

  // channel table
  adcseq_table u_table (
    .clk (clk),
    .rst (rst),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

  // decode, request state, result stage
  adcseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .tbl_req   (tbl_req),
    .tbl_rsp   (tbl_rsp),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  // output decoupling: ready towards the core never sees results.ready
  adcseq_skid u_skid (
    .clk     (clk),
    .rst     (rst),
    .valid   (res_valid),
    .data    (res_data),
    .ready   (res_ready),
    .results (results)
  );

endmodule

// ===== dv/adc_scan_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_scan_sequencer_tb
// Self-checking bench for the ADC scan sequencer. Command beats are driven
// over valid/ready with random gaps and random result back-pressure. Every
// accepted beat runs through a behavioural copy of the sequencer, and each
// result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module adc_scan_sequencer_tb;
  import adcseq_pkg::*;

  localparam int         CLK_PERIOD  = 8;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0] CMD_LAST    = 3'd7;   // top of the unused command codes
  localparam logic [4:0] CHAN_MAX    = 5'd31;  // widest channel field value
  localparam logic [3:0] LEN_MAX     = 4'd15;  // widest chain length field value
  localparam logic [15:0] LIMIT_MAX  = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  adcseq_in_if  items_if ();
  adcseq_out_if results_if ();

  adc_scan_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .results   (results_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  out_item_t   pending_results [$];  // predicted result beats, oldest first
  int          mismatches   = 0;
  int          useful_items = 0;     // beats the sequencer did not just ignore
  int          cycles       = 0;
  bit          idle_on      = 1'b1;  // random gaps and stalls on both sides

  // behavioural copy of the sequencer state and its registers
  logic [4:0]  m_table [TABLE_DEPTH] = '{default: '0};
  logic        m_busy   = 1'b0;
  logic [1:0]  m_mode   = MODE_SINGLE;
  logic [3:0]  m_total  = '0;
  logic [2:0]  m_pos    = '0;
  logic [15:0] m_ticks  = '0;
  logic        m_left   = 1'b0;
  logic [15:0] m_limit  = TIMEOUT_RESET;

  // --------------------------------------------------------------------------
  // Predictor: next result beat of the sequencer for one command beat.
  // Argument checks come ahead of the busy check for both start commands.
  // --------------------------------------------------------------------------
  function automatic out_item_t sequencer_next(input in_item_t it);
    out_item_t r;
    logic      ok;
    r = '0;
    case (it.cmd)
      CMD_LOAD: begin
        // a load while busy leaves the table alone; bad channels are stored
        if (m_busy) r.status = ST_BUSY;
        else m_table[it.slot] = it.channel;
      end
      CMD_SINGLE: begin
        if (it.channel > LAST_CHANNEL) begin
          r.status = ST_INVALID;
        end else if (m_busy) begin
          r.status = ST_BUSY;
        end else begin
          m_busy  = 1'b1;
          m_mode  = it.polled ? MODE_POLLED : MODE_SINGLE;
          m_ticks = '0;
          r.start_conversion = 1'b1;
          r.mux_channel      = it.channel[2:0];
        end
      end
      CMD_CHAIN: begin
        // length 1..MAX_CHAIN, and every slot it covers must hold a real channel
        ok = (it.chain_length != 0) && (it.chain_length <= MAX_CHAIN);
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (ok && i < it.chain_length && m_table[i] > LAST_CHANNEL) ok = 1'b0;
        if (!ok) begin
          r.status = ST_INVALID;
        end else if (m_busy) begin
          r.status = ST_BUSY;
        end else begin
          m_busy  = 1'b1;
          m_mode  = MODE_CHAIN;
          m_total = it.chain_length;
          m_pos   = '0;
          r.start_conversion = 1'b1;
          r.mux_channel      = m_table[0][2:0];
        end
      end
      CMD_DONE: begin
        if (!m_busy) begin
          r.status = ST_IGNORED;
        end else begin
          // left adjust: ADCH holds bits 9:2, ADCL bits 7:6 hold bits 1:0
          r.sample_value = m_left ? {it.raw_data[15:8], it.raw_data[7:6]}
                                  : it.raw_data[9:0];
          r.sample_valid = 1'b1;
          if (m_mode == MODE_CHAIN) begin
            r.sample_index = m_pos;
            m_pos = m_pos + 3'd1;
            if (int'(r.sample_index) + 1 >= int'(m_total)) begin
              r.finished = 1'b1;
              m_busy     = 1'b0;
            end else begin
              r.start_conversion = 1'b1;
              r.mux_channel      = m_table[m_pos][2:0];
            end
          end else begin
            r.finished = 1'b1;
            m_busy     = 1'b0;
          end
        end
      end
      CMD_TICK: begin
        // ticks only count against a polled single conversion
        if (m_busy && m_mode == MODE_POLLED) begin
          m_ticks = m_ticks + 16'd1;
          if (m_ticks >= m_limit) begin
            r.status   = ST_TIMEOUT;
            r.finished = 1'b1;
            m_busy     = 1'b0;
          end
        end else begin
          r.status = ST_IGNORED;
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    r.busy_res = m_busy;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // --------------------------------------------------------------------------
  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // result sink: random stalls, one check per accepted beat
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && results_if.valid && results_if.ready) begin
      got = results_if.data;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat with nothing outstanding (status 0x%0h)", got.status));
      end else begin
        want = pending_results.pop_front();
        check_field("status",           got.status,           want.status);
        check_field("sample_value",     got.sample_value,     want.sample_value);
        check_field("sample_valid",     got.sample_valid,     want.sample_valid);
        check_field("sample_index",     got.sample_index,     want.sample_index);
        check_field("start_conversion", got.start_conversion, want.start_conversion);
        check_field("mux_channel",      got.mux_channel,      want.mux_channel);
        check_field("finished",         got.finished,         want.finished);
        check_field("busy_res",         got.busy_res,         want.busy_res);
      end
    end
    results_if.ready <= !(idle_on && $urandom_range(99) < 33);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("adc_scan_sequencer: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one command beat; prediction happens at the accepting edge
  task automatic send_item(input in_item_t it);
    out_item_t r;
    if (idle_on)
      while ($urandom_range(99) < 33) begin
        items_if.valid <= 1'b0;
        @(posedge clk);
      end
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    do @(posedge clk); while (!items_if.ready);
    r = sequencer_next(it);
    pending_results.push_back(r);
    if (r.status != ST_IGNORED) useful_items++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_results_drained();
    items_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write; the sequencer must be drained first
  task automatic program_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_LEFT_ADJUST) m_left = val[0];
    else m_limit = val;
  endtask

  // unused fields carry random bits on every beat
  function automatic in_item_t rand_item();
    in_item_t it;
    it = $urandom;
    return it;
  endfunction

  function automatic logic [4:0] pick_channel();
    if ($urandom_range(99) < 90) return 5'($urandom_range(LAST_CHANNEL));
    return 5'($urandom_range(CHAN_MAX));
  endfunction

  task automatic do_cmd(input logic [2:0] cmd);
    in_item_t it;
    it = rand_item();
    it.cmd = cmd;
    send_item(it);
  endtask

  task automatic do_load(input logic [2:0] slot, input logic [4:0] ch);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_LOAD; it.slot = slot; it.channel = ch;
    send_item(it);
  endtask

  task automatic do_single(input logic [4:0] ch, input logic polled);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_SINGLE; it.channel = ch; it.polled = polled;
    send_item(it);
  endtask

  task automatic do_chain(input logic [3:0] len);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_CHAIN; it.chain_length = len;
    send_item(it);
  endtask

  task automatic do_done(input logic [15:0] raw);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_DONE; it.raw_data = raw;
    send_item(it);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // events with nothing running, bad arguments, busy rejection, basic runs
  task automatic test_directed();
    do_cmd(CMD_TICK);                    // tick while idle
    do_done(16'hFFFF);                   // done while idle
    do_cmd(CMD_TICK + 3'd1);             // unused codes
    do_cmd(CMD_LAST);
    do_load(3'd0, 5'd7);
    do_load(3'd1, 5'd0);
    do_load(3'd2, 5'd5);
    do_load(3'd7, CHAN_MAX);             // bad channel is stored
    do_chain(4'd0);                      // zero length
    do_chain(LEN_MAX);                   // longer than the table
    do_chain(4'd8);                      // slot 7 holds a bad channel
    do_single(CHAN_MAX, 1'b0);
    do_single(5'd8, 1'b1);               // first channel past the end
    do_single(5'd7, 1'b0);
    do_single(5'd3, 1'b0);               // busy
    do_chain(4'd0);                      // argument check beats busy
    do_load(3'd4, 5'd2);                 // load while busy: table kept
    do_cmd(CMD_TICK);                    // tick on a non-polled request
    do_done(16'hFFFF);
    do_chain(4'd3);
    do_done(16'h0000);
    do_done(16'hFC00);                   // upper bits masked off
    do_done(16'hA5C3);
    do_single(5'd0, 1'b1);               // polled under the reset limit
    do_cmd(CMD_TICK);
    do_done(16'h0155);
  endtask

  // left-adjusted unpacking, full eight-entry chain
  task automatic test_left_adjust();
    wait_results_drained();
    program_reg(CFG_LEFT_ADJUST, 16'd1);
    do_single(5'd1, 1'b0);
    do_done(16'hFFFF);
    do_single(5'd2, 1'b1);
    do_done(16'h00C0);
    do_load(3'd7, 5'd6);
    do_chain(4'd8);
    do_done(16'h8040);
    repeat (7) do_done(16'($urandom));
  endtask

  // polled timeouts at small limits, the smallest included
  task automatic test_timeout();
    wait_results_drained();
    program_reg(CFG_TIMEOUT, 16'd1);
    do_single(5'd6, 1'b1);
    do_cmd(CMD_TICK);                    // times out at once
    do_cmd(CMD_TICK);                    // idle again
    wait_results_drained();
    program_reg(CFG_TIMEOUT, 16'd3);
    program_reg(CFG_LEFT_ADJUST, 16'd0);
    do_single(5'd5, 1'b1);
    repeat (3) do_cmd(CMD_TICK);
    do_single(5'd4, 1'b1);               // counter restarts
    repeat (2) do_cmd(CMD_TICK);
    do_done(16'h03FF);
  endtask

  // largest limit: ticks keep counting with no timeout, no gaps or stalls
  task automatic test_timeout_max();
    wait_results_drained();
    program_reg(CFG_TIMEOUT, LIMIT_MAX);
    idle_on = 1'b0;
    do_single(5'd4, 1'b1);
    repeat (40) do_cmd(CMD_TICK);
    do_done(16'h02AA);
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  // mostly well-formed load/start/done sequences with noise mixed in
  task automatic run_sequences(input int target);
    int first;
    int guard;
    first = useful_items;
    while (useful_items - first < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(TABLE_DEPTH))
            do_load(3'($urandom_range(TABLE_DEPTH - 1)), pick_channel());
          if ($urandom_range(9) == 0) do_chain(4'($urandom_range(LEN_MAX)));
          else do_chain(4'($urandom_range(1, MAX_CHAIN)));
          guard = 0;
          while (m_busy && guard < 40) begin
            if ($urandom_range(99) < 65) do_done(16'($urandom));
            else send_item(rand_item());
            guard++;
          end
          while (m_busy) do_done(16'($urandom));
        end
        4, 5, 6: begin
          do_single(pick_channel(), 1'($urandom_range(1)));
          guard = 0;
          while (m_busy && guard < 30) begin
            case ($urandom_range(3))
              0, 1: do_cmd(CMD_TICK);
              2: do_done(16'($urandom));
              default: send_item(rand_item());
            endcase
            guard++;
          end
        end
        7: repeat ($urandom_range(1, 5)) send_item(rand_item());
        default:
          repeat ($urandom_range(1, 4))
            do_load(3'($urandom_range(TABLE_DEPTH - 1)), 5'($urandom_range(CHAN_MAX)));
      endcase
      // now and then hold off until everything outstanding has come back
      if ($urandom_range(49) == 0) wait_results_drained();
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      wait_results_drained();
      case (phase)
        0: begin
          program_reg(CFG_LEFT_ADJUST, 16'd0);
          program_reg(CFG_TIMEOUT, 16'd1);
        end
        1: begin
          program_reg(CFG_LEFT_ADJUST, 16'd1);
          program_reg(CFG_TIMEOUT, 16'($urandom_range(2, 30)));
        end
        2: begin
          program_reg(CFG_LEFT_ADJUST, 16'd0);
          program_reg(CFG_TIMEOUT, LIMIT_MAX);
        end
        3: begin
          program_reg(CFG_LEFT_ADJUST, 16'd1);
          program_reg(CFG_TIMEOUT, 16'd1);
        end
        4: begin
          program_reg(CFG_LEFT_ADJUST, 16'($urandom_range(1)));
          program_reg(CFG_TIMEOUT, 16'($urandom_range(1, 40)));
        end
        default: begin
          program_reg(CFG_LEFT_ADJUST, 16'd1);
          program_reg(CFG_TIMEOUT, TIMEOUT_RESET);
        end
      endcase
      // one phase runs flat out on both sides
      idle_on = (phase != 2);
      run_sequences(170);
    end
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_LEFT_ADJUST;
    cfg_data       <= '0;
    items_if.valid <= 1'b0;
    items_if.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_left_adjust();
    test_timeout();
    test_timeout_max();
    test_random();

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("adc_scan_sequencer: match");
    else $display("adc_scan_sequencer: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/adcseq_pkg.sv
sv/adcseq_if.sv
sv/adcseq_table.sv
sv/adcseq_skid.sv
sv/adcseq_ctrl.sv
sv/adc_scan_sequencer.sv
dv/adc_scan_sequencer_tb.sv
